>>> hw/rtl/fdem_pkg.sv
// Shared types, widths, codes and reset values of the filled-disk erase unit.
package fdem_pkg;

    // Fixed field widths
    localparam int OP_W       = 2;
    localparam int POS_X_W    = 10;
    localparam int POS_Y_W    = 9;
    localparam int AREA_W_W   = 11;
    localparam int AREA_H_W   = 10;
    localparam int RADIUS_W   = 6;
    localparam int ERR_W      = 9;
    localparam int OCT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    // signed point coordinate: centre plus or minus the largest radius
    localparam int PT_W       = 12;

    // Default map size
    localparam int MAP_COLUMNS_DEF = 1024;
    localparam int MAP_ROWS_DEF    = 512;

    // Configuration reset values
    localparam logic [AREA_W_W-1:0] AREA_WIDTH_RST   = 11'd1024;
    localparam logic [AREA_H_W-1:0] AREA_HEIGHT_RST  = 10'd512;
    localparam logic [RADIUS_W-1:0] BLAST_RADIUS_RST = 6'd40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLAST_RADIUS = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_EXPLODE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POINT,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic load_item;
        logic issue_pixel;
        logic ring_start;
        logic issue_point;
        logic ring_next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            last_oct;
        logic            ring_done;
        logic            ring_zero;
        logic            pipe_empty;
        logic            out_free;
    } t_status;

endpackage

>>> hw/rtl/fdem_in_if.sv
// Input word channel: operation, position and pixel value.
interface fdem_in_if;
    logic                         valid;
    logic                         ready;
    logic [fdem_pkg::OP_W-1:0]    op;
    logic [fdem_pkg::POS_X_W-1:0] pos_x;
    logic [fdem_pkg::POS_Y_W-1:0] pos_y;
    logic                         solid_in;

    modport source (output valid, op, pos_x, pos_y, solid_in, input ready);
    modport sink   (input valid, op, pos_x, pos_y, solid_in, output ready);
endinterface

>>> hw/rtl/fdem_out_if.sv
// Result word channel: read pixel and completion flag.
interface fdem_out_if;
    logic valid;
    logic ready;
    logic solid_out;
    logic done_res;

    modport source (output valid, solid_out, done_res, input ready);
    modport sink   (input valid, solid_out, done_res, output ready);
endinterface

>>> hw/rtl/fdem_ram.sv
// Generic single-port RAM with registered read.
module fdem_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/fdem_ctrl.sv
// Sequencing state machine: decode, circle point issue, drain and result hand-off.
module fdem_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fdem_pkg::t_status i_status,
    output fdem_pkg::t_cmd    o_cmd
);

    fdem_pkg::t_state r_state;
    fdem_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdem_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fdem_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fdem_pkg::ST_DECODE;
                end
            end
            fdem_pkg::ST_DECODE: begin
                if (i_status.op == fdem_pkg::OP_EXPLODE) begin
                    n_state = fdem_pkg::ST_POINT;
                end else begin
                    n_state = fdem_pkg::ST_DRAIN;
                end
            end
            fdem_pkg::ST_POINT: begin
                if (i_status.last_oct && i_status.ring_done && i_status.ring_zero) begin
                    n_state = fdem_pkg::ST_DRAIN;
                end
            end
            fdem_pkg::ST_DRAIN: begin
                if (i_status.pipe_empty && i_status.out_free) begin
                    n_state = fdem_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fdem_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fdem_pkg::ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_item   = i_in_valid;
            end
            fdem_pkg::ST_DECODE: begin
                o_cmd.issue_pixel = (i_status.op == fdem_pkg::OP_WRITE) ||
                                    (i_status.op == fdem_pkg::OP_READ);
                o_cmd.ring_start  = (i_status.op == fdem_pkg::OP_EXPLODE);
            end
            fdem_pkg::ST_POINT: begin
                o_cmd.issue_point = 1'b1;
                o_cmd.ring_next   = i_status.last_oct && i_status.ring_done &&
                                    !i_status.ring_zero;
            end
            fdem_pkg::ST_DRAIN: begin
                o_cmd.out_load    = i_status.pipe_empty && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // result only once every mask access has landed
    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.pipe_empty)
        else $error("result loaded with accesses in flight");

    // no new word while an explosion is tracing
    a_no_accept_in_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue_point |-> !o_in_ready && !o_cmd.load_item)
        else $error("input accepted during explosion");

endmodule

>>> hw/rtl/fdem_dpath.sv
// Datapath: config, item and circle registers, point pipeline, mask RAM, result register.
module fdem_dpath #(
    parameter int MAP_COLUMNS = fdem_pkg::MAP_COLUMNS_DEF,
    parameter int MAP_ROWS    = fdem_pkg::MAP_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fdem_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fdem_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [fdem_pkg::OP_W-1:0]         i_op,
    input  logic [fdem_pkg::POS_X_W-1:0]      i_pos_x,
    input  logic [fdem_pkg::POS_Y_W-1:0]      i_pos_y,
    input  logic                              i_solid,
    input  fdem_pkg::t_cmd                    i_cmd,
    output fdem_pkg::t_status                 o_status,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_out_solid
);

    localparam int COL_W  = $clog2(MAP_COLUMNS);
    localparam int ROW_W  = $clog2(MAP_ROWS);
    localparam int DEPTH  = MAP_COLUMNS * MAP_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PW     = fdem_pkg::PT_W;
    localparam int RW     = fdem_pkg::RADIUS_W;

    // configuration
    logic [fdem_pkg::AREA_W_W-1:0] r_area_w;
    logic [fdem_pkg::AREA_H_W-1:0] r_area_h;
    logic [RW-1:0]                 r_radius;
    logic [COL_W:0]                eff_w;
    logic [ROW_W:0]                eff_h;

    // item
    logic [fdem_pkg::OP_W-1:0]    r_op;
    logic [fdem_pkg::POS_X_W-1:0] r_cx;
    logic [fdem_pkg::POS_Y_W-1:0] r_cy;
    logic                         r_solid;

    // circle tracer
    logic [RW-1:0]                     r_cir_x;
    logic [RW-1:0]                     r_cir_y;
    logic signed [fdem_pkg::ERR_W-1:0] r_cir_err;
    logic [RW-1:0]                     r_ring;
    logic [fdem_pkg::OCT_W-1:0]        r_oct;

    logic [RW-1:0]        init_r;
    logic signed [7:0]    s_x;
    logic signed [7:0]    s_y;
    logic signed [10:0]   e_ext;
    logic signed [10:0]   x_ext;
    logic signed [10:0]   y_ext;
    logic signed [10:0]   err_sum;
    logic                 err_neg;

    // point generation
    logic [RW-1:0]        dx;
    logic [RW-1:0]        dy;
    logic                 x_neg;
    logic                 y_neg;
    logic [PW-1:0]        pt_x;
    logic [PW-1:0]        pt_y;
    logic                 pt_ok;

    // pipeline
    logic                 r_s1_valid;
    logic                 r_s1_ok;
    logic [COL_W-1:0]     r_s1_x;
    logic [ROW_W-1:0]     r_s1_y;
    logic                 r_s1_we;
    logic                 r_s1_wd;
    logic                 r_s2_valid;
    logic                 r_s2_ok;
    logic [ADDR_W-1:0]    r_s2_addr;
    logic                 r_s2_we;
    logic                 r_s2_wd;
    logic                 r_rd_ok;
    logic [COL_W+ROW_W:0] prod;
    logic [ADDR_W-1:0]    n_addr;
    logic                 ram_we;
    logic                 ram_re;
    logic [0:0]           ram_rdata;

    logic                 r_out_valid;
    logic                 r_out_solid;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_w <= fdem_pkg::AREA_WIDTH_RST;
            r_area_h <= fdem_pkg::AREA_HEIGHT_RST;
            r_radius <= fdem_pkg::BLAST_RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fdem_pkg::CFG_AREA_WIDTH:   r_area_w <= i_cfg_data;
                fdem_pkg::CFG_AREA_HEIGHT:  r_area_h <= i_cfg_data[fdem_pkg::AREA_H_W-1:0];
                fdem_pkg::CFG_BLAST_RADIUS: r_radius <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // area clipped to the map
    always_comb begin
        if (32'(r_area_w) < 32'(MAP_COLUMNS)) begin
            eff_w = (COL_W+1)'(r_area_w);
        end else begin
            eff_w = (COL_W+1)'(MAP_COLUMNS);
        end
        if (32'(r_area_h) < 32'(MAP_ROWS)) begin
            eff_h = (ROW_W+1)'(r_area_h);
        end else begin
            eff_h = (ROW_W+1)'(MAP_ROWS);
        end
    end

    // ---------------- item register ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_op;
            r_cx    <= i_pos_x;
            r_cy    <= i_pos_y;
            r_solid <= i_solid;
        end
    end

    // ---------------- midpoint step ----------------
    always_comb begin
        err_neg = r_cir_err[fdem_pkg::ERR_W-1];
        s_y     = $signed({2'b00, r_cir_y}) + 8'sd1;
        s_x     = err_neg ? $signed({2'b00, r_cir_x}) : $signed({2'b00, r_cir_x}) - 8'sd1;
        e_ext   = {{2{r_cir_err[fdem_pkg::ERR_W-1]}}, r_cir_err};
        x_ext   = {{3{s_x[7]}}, s_x};
        y_ext   = {{3{s_y[7]}}, s_y};
        if (err_neg) begin
            err_sum = e_ext + (y_ext <<< 1) + 11'sd1;
        end else begin
            err_sum = e_ext + ((y_ext - x_ext + 11'sd1) <<< 1);
        end
        init_r  = i_cmd.ring_start ? r_radius : r_ring - RW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cir_x   <= '0;
            r_cir_y   <= '0;
            r_cir_err <= '0;
            r_ring    <= '0;
            r_oct     <= '0;
        end else if (i_cmd.ring_start || i_cmd.ring_next) begin
            r_ring    <= init_r;
            r_cir_x   <= init_r;
            r_cir_y   <= '0;
            r_cir_err <= $signed(9'd1) - $signed({3'b000, init_r});
            r_oct     <= '0;
        end else if (i_cmd.issue_point) begin
            r_oct <= r_oct + fdem_pkg::OCT_W'(1);
            if (r_oct == '1) begin
                r_cir_x   <= s_x[RW-1:0];
                r_cir_y   <= s_y[RW-1:0];
                r_cir_err <= err_sum[fdem_pkg::ERR_W-1:0];
            end
        end
    end

    // ---------------- point generation ----------------
    // octants: odd ones swap x and y; 2..5 mirror x; 4..7 mirror y
    always_comb begin
        if (i_cmd.issue_point) begin
            dx = r_oct[0] ? r_cir_y : r_cir_x;
            dy = r_oct[0] ? r_cir_x : r_cir_y;
        end else begin
            dx = '0;
            dy = '0;
        end
        x_neg = r_oct[2] ^ r_oct[1];
        y_neg = r_oct[2];
        pt_x  = x_neg ? PW'(r_cx) - PW'(dx) : PW'(r_cx) + PW'(dx);
        pt_y  = y_neg ? PW'(r_cy) - PW'(dy) : PW'(r_cy) + PW'(dy);
        pt_ok = !pt_x[PW-1] && !pt_y[PW-1] &&
                (32'(pt_x[PW-2:0]) < 32'(eff_w)) &&
                (32'(pt_y[PW-2:0]) < 32'(eff_h));
    end

    // ---------------- access pipeline ----------------
    always_comb begin
        prod   = r_s1_x * eff_h;
        n_addr = ADDR_W'(prod) + ADDR_W'(r_s1_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue_pixel || i_cmd.issue_point;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ok   <= pt_ok;
        r_s1_x    <= COL_W'(pt_x[PW-2:0]);
        r_s1_y    <= ROW_W'(pt_y[PW-2:0]);
        r_s1_we   <= i_cmd.issue_point || (r_op == fdem_pkg::OP_WRITE);
        r_s1_wd   <= i_cmd.issue_pixel && r_solid;
        r_s2_ok   <= r_s1_ok;
        r_s2_addr <= n_addr;
        r_s2_we   <= r_s1_we;
        r_s2_wd   <= r_s1_wd;
        if (r_s2_valid && !r_s2_we) begin
            r_rd_ok <= r_s2_ok;
        end
    end

    assign ram_we = r_s2_valid && r_s2_ok && r_s2_we;
    assign ram_re = r_s2_valid && r_s2_ok && !r_s2_we;

    fdem_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_s2_addr),
        .i_wdata (r_s2_wd),
        .o_rdata (ram_rdata)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_solid <= (r_op == fdem_pkg::OP_READ) && r_rd_ok && ram_rdata[0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_solid = r_out_solid;

    always_comb begin
        o_status.op         = r_op;
        o_status.last_oct   = (r_oct == '1);
        o_status.ring_done  = (s_x < s_y);
        o_status.ring_zero  = (r_ring == '0);
        o_status.pipe_empty = !r_s1_valid && !r_s2_valid;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // a point passed as inside really lies in the area
    a_s1_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_ok |-> (32'(r_s1_x) < 32'(eff_w)) && (32'(r_s1_y) < 32'(eff_h)))
        else $error("clipped point outside area");

    // octant points only come from the first octant of a circle
    a_trace_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue_point |-> r_cir_x >= r_cir_y)
        else $error("circle step beyond the diagonal");

endmodule

>>> hw/rtl/filled_disk_erase_midpoint_unit.sv
// Write/read: decode, then pipeline stages s1 and s2 and the mask RAM, then the result word;
//   an unused op goes from decode to drain. Explosion: eight octant points per circle step
//   (one octant point per mask-port cycle) over radii blast_radius..0, then pipeline drain.
// Flow: one word in flight, next word taken in the cycle after the result is loaded;
//   the single mask RAM port sets the point rate, a result word still held stalls drain.
// Reset (i_rst_n, synchronous, active low): control and circle registers cleared, config
//   to its defaults; the pixel mask is not initialised and holds nothing defined until written.
module filled_disk_erase_midpoint_unit #(
    parameter int MAP_COLUMNS = fdem_pkg::MAP_COLUMNS_DEF,
    parameter int MAP_ROWS    = fdem_pkg::MAP_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes, to be issued only while idle
    input  logic                            i_cfg_we,
    input  logic [fdem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fdem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // operation words in, result words out
    fdem_in_if.sink                         i_cmd,
    fdem_out_if.source                      o_res
);

    fdem_pkg::t_cmd    cmd;
    fdem_pkg::t_status status;
    logic              in_ready;
    logic              out_valid;
    logic              out_solid;

    // Controller: idle -> decode -> (point trace) -> drain -> result.
    // Accepts a word only in idle; a result word still pending in the result register holds
    // drain, so it also holds the next accept.
    fdem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: midpoint tracer, clip, x*H+y address multiply (registered),
    // mask RAM access, result register.
    fdem_dpath #(
        .MAP_COLUMNS (MAP_COLUMNS),
        .MAP_ROWS    (MAP_ROWS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_cmd.op),
        .i_pos_x     (i_cmd.pos_x),
        .i_pos_y     (i_cmd.pos_y),
        .i_solid     (i_cmd.solid_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_res.ready),
        .o_out_valid (out_valid),
        .o_out_solid (out_solid)
    );

    assign i_cmd.ready     = in_ready;
    assign o_res.valid     = out_valid;
    assign o_res.solid_out = out_solid;
    // every operation completes before its word is shown
    assign o_res.done_res  = 1'b1;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the filled-disk erase unit: pixel writes, reads and explosions.
module testbench;
    import fdem_pkg::*;

    localparam int MAP_COLS   = MAP_COLUMNS_DEF;
    localparam int MAP_LINES  = MAP_ROWS_DEF;
    localparam int MASK_DEPTH = MAP_COLS * MAP_LINES;
    localparam int X_MAX      = (1 << POS_X_W) - 1;
    localparam int Y_MAX      = (1 << POS_Y_W) - 1;
    // op code 3 has no meaning in the block; it must come back as an empty result word
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    // a radius-63 explosion moves no word on either side while it traces; the limit must cover it
    localparam int QUIET_LIMIT   = 200000;
    // idle time after the last result before touching the registers
    localparam int SETTLE_CYCLES = 8;
    localparam int PLAN_ROWS     = 30;
    localparam int PHASES        = 10;

    typedef enum bit {ROW_WORD, ROW_CFG} t_row_kind;

    // one row of the directed plan: either a register setting or one input word
    typedef struct packed {
        t_row_kind             kind;
        logic [AREA_W_W-1:0]   w;
        logic [AREA_H_W-1:0]   h;
        logic [RADIUS_W-1:0]   r;
        logic [OP_W-1:0]       op;
        logic [POS_X_W-1:0]    x;
        logic [POS_Y_W-1:0]    y;
        logic                  solid;
        bit                    has_lit;
        logic                  lit;
    } t_row;

    typedef struct packed {
        int w;
        int h;
        int r;
        int words;
        int boom_pct;
    } t_phase;

    typedef struct packed {
        logic solid;
        logic done;
    } t_result;

    typedef struct packed {
        bit   has;
        logic val;
    } t_typed;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fdem_in_if  cmd_if ();
    fdem_out_if res_if ();

    filled_disk_erase_midpoint_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if.sink),
        .o_res      (res_if.source)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Mask predictor: own copy of the pixel store and the three registers.
    // mask_known marks entries that hold a defined value (written or blasted),
    // so reads are only ever aimed at those.
    // ------------------------------------------------------------------
    bit mask_bits  [MASK_DEPTH];
    bit mask_known [MASK_DEPTH];
    int area_w_q;
    int area_h_q;
    int radius_q;

    t_result due_results [$];
    t_typed  typed_answers [$];

    int words_sent    = 0;
    int results_seen  = 0;
    int reads_sent    = 0;
    int blasts        = 0;
    int settings_seen = 0;
    int fail_count    = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;

    // oversized registers clip to the map; zero leaves no pixel valid
    function automatic int eff_cols();
        return (area_w_q < MAP_COLS) ? area_w_q : MAP_COLS;
    endfunction

    function automatic int eff_rows();
        return (area_h_q < MAP_LINES) ? area_h_q : MAP_LINES;
    endfunction

    function automatic bit on_map(input int px, input int py);
        return px >= 0 && py >= 0 && px < eff_cols() && py < eff_rows();
    endfunction

    // column-major: the row count of the current setting is the stride
    function automatic int pix_addr(input int px, input int py);
        return px * eff_rows() + py;
    endfunction

    function automatic void erase_px(input int px, input int py);
        if (on_map(px, py)) begin
            mask_bits[pix_addr(px, py)]  = 1'b0;
            mask_known[pix_addr(px, py)] = 1'b1;
        end
    endfunction

    // one midpoint circle, eight octant points per step, off-map points dropped
    function automatic void trace_circle(input int r, input int cx, input int cy);
        int dx;
        int dy;
        int err;
        dx  = r;
        dy  = 0;
        err = 1 - r;
        while (dx >= dy) begin
            erase_px(cx + dx, cy + dy);
            erase_px(cx + dy, cy + dx);
            erase_px(cx - dx, cy + dy);
            erase_px(cx - dy, cy + dx);
            erase_px(cx - dx, cy - dy);
            erase_px(cx - dy, cy - dx);
            erase_px(cx + dx, cy - dy);
            erase_px(cx + dy, cy - dx);
            dy++;
            if (err < 0) begin
                err += 2 * dy + 1;
            end else begin
                dx--;
                err += 2 * (dy - dx + 1);
            end
        end
    endfunction

    // applies one word to the mask and returns the expected solid_out
    function automatic logic mask_step(input logic [OP_W-1:0] op, input int px, input int py,
                                       input logic s);
        logic solid;
        solid = 1'b0;
        case (op)
            OP_WRITE: begin
                if (on_map(px, py)) begin
                    mask_bits[pix_addr(px, py)]  = s;
                    mask_known[pix_addr(px, py)] = 1'b1;
                end
            end
            OP_READ: begin
                if (on_map(px, py))
                    solid = mask_bits[pix_addr(px, py)];
            end
            OP_EXPLODE: begin
                // rings from the full radius down to the centre point itself
                for (int r = radius_q; r >= 0; r--)
                    trace_circle(r, px, py);
            end
            default: ;
        endcase
        return solid;
    endfunction

    function automatic t_row word_row(input logic [OP_W-1:0] op, input int px, input int py,
                                      input logic s, input bit has, input logic lit);
        t_row entry;
        entry         = '0;
        entry.kind    = ROW_WORD;
        entry.op      = op;
        entry.x       = POS_X_W'(px);
        entry.y       = POS_Y_W'(py);
        entry.solid   = s;
        entry.has_lit = has;
        entry.lit     = lit;
        return entry;
    endfunction

    function automatic t_row cfg_row(input int w, input int h, input int r);
        t_row entry;
        entry      = '0;
        entry.kind = ROW_CFG;
        entry.w    = AREA_W_W'(w);
        entry.h    = AREA_H_W'(h);
        entry.r    = RADIUS_W'(r);
        return entry;
    endfunction

    // mostly a window round the focus, now and then anywhere in the field range
    function automatic void pick_pos(input int fx, input int fy, input int win,
                                     output int px, output int py);
        if ($urandom_range(0, 99) < 15) begin
            px = $urandom_range(0, X_MAX);
            py = $urandom_range(0, Y_MAX);
        end else begin
            px = fx + int'($urandom_range(0, 2 * win)) - win;
            py = fy + int'($urandom_range(0, 2 * win)) - win;
            if (px < 0) px = 0;
            if (px > X_MAX) px = X_MAX;
            if (py < 0) py = 0;
            if (py > Y_MAX) py = Y_MAX;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: random gaps, mostly short, some long, with gap-free bursts.
    // Returns at the accepting edge with valid still high, so the caller
    // either drives the next word or lowers valid in that same step.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [OP_W-1:0] op, input int px, input int py,
                             input logic s, input bit has_lit, input logic lit);
        int gap;
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                burst_left = $urandom_range(20, 80);
                gap = 0;
            end else if (pick < 50) begin
                gap = 0;
            end else if (pick < 85) begin
                gap = $urandom_range(1, 3);
            end else if (pick < 96) begin
                gap = $urandom_range(4, 12);
            end else begin
                gap = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed_answers.push_back('{has_lit, lit});
        cmd_if.valid    <= 1'b1;
        cmd_if.op       <= op;
        cmd_if.pos_x    <= POS_X_W'(px);
        cmd_if.pos_y    <= POS_Y_W'(py);
        cmd_if.solid_in <= s;
        do @(posedge i_clk); while (!cmd_if.ready);
        words_sent++;
        if (op == OP_READ) reads_sent++;
        if (op == OP_EXPLODE) blasts++;
    endtask

    // hold the sender off until every word has its result, then wait a little more
    task automatic drain_results(input int settle);
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (results_seen < words_sent);
        repeat (settle) @(posedge i_clk);
    endtask

    // all three registers, back to back, only with the block idle
    task automatic set_config(input int w, input int h, input int r);
        drain_results(SETTLE_CYCLES);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_AREA_WIDTH;
        i_cfg_data <= CFG_DATA_W'(w);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_AREA_HEIGHT;
        i_cfg_data <= CFG_DATA_W'(h);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BLAST_RADIUS;
        i_cfg_data <= CFG_DATA_W'(r);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        area_w_q = w & 'h7FF;
        area_h_q = h & 'h3FF;
        radius_q = r & 'h3F;
        settings_seen++;
    endtask

    // Random phase: a focus window slightly wider than the blast, so writes,
    // blasts and read-backs land on the same pixels. Reads are only aimed at
    // defined entries; failing that after a few tries the word becomes a write.
    task automatic run_phase(input int w, input int h, input int r, input int words,
                             input int boom_pct);
        int fx;
        int fy;
        int win;
        int px;
        int py;
        int pick;
        int tries;
        logic [OP_W-1:0] op;
        set_config(w, h, r);
        fx  = 0;
        fy  = 0;
        win = radius_q + 3;
        for (int n = 0; n < words; n++) begin
            if (n % 40 == 0) begin
                fx = (eff_cols() > 0) ? int'($urandom_range(0, eff_cols() - 1))
                                      : int'($urandom_range(0, X_MAX));
                fy = (eff_rows() > 0) ? int'($urandom_range(0, eff_rows() - 1))
                                      : int'($urandom_range(0, Y_MAX));
            end
            // now and then the sender waits for the block to run dry
            if ($urandom_range(0, 99) == 0)
                drain_results(0);
            pick = $urandom_range(0, 99);
            if (pick < boom_pct)
                op = OP_EXPLODE;
            else if (pick < boom_pct + 3)
                op = OP_SPARE;
            else if (pick < 55)
                op = OP_WRITE;
            else
                op = OP_READ;
            tries = 0;
            do begin
                pick_pos(fx, fy, win, px, py);
                tries++;
            end while (op == OP_READ && on_map(px, py) && !mask_known[pix_addr(px, py)]
                       && tries < 8);
            if (op == OP_READ && on_map(px, py) && !mask_known[pix_addr(px, py)])
                op = OP_WRITE;
            send_word(op, px, py, $urandom_range(0, 9) < 7, 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts at input acceptance, checks at result acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_typed  typed;
        t_result want;
        logic    solid;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            solid = mask_step(cmd_if.op, int'(cmd_if.pos_x), int'(cmd_if.pos_y),
                              cmd_if.solid_in);
            typed = typed_answers.pop_front();
            if (typed.has)
                solid = typed.val;
            due_results.push_back('{solid, 1'b1});
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                $error("result word with nothing outstanding: solid_out %0b done_res %0b",
                       res_if.solid_out, res_if.done_res);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (res_if.solid_out !== want.solid) begin
                    $error("solid_out mismatch: expected %0b, got %0b",
                           want.solid, res_if.solid_out);
                    fail_count++;
                end
                if (res_if.done_res !== want.done) begin
                    $error("done_res mismatch: expected %0b, got %0b",
                           want.done, res_if.done_res);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, mostly short, a few long, and calm stretches
    initial begin
        int stall_left;
        int calm_left;
        int pick;
        res_if.ready <= 1'b0;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge i_clk);
            if (calm_left > 0) begin
                calm_left--;
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    calm_left = $urandom_range(50, 400);
                    res_if.ready <= 1'b1;
                end else if (pick < 17) begin
                    stall_left = $urandom_range(0, 3);
                    res_if.ready <= 1'b0;
                end else if (pick < 20) begin
                    stall_left = $urandom_range(10, 50);
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row   plan [PLAN_ROWS];
        t_phase phases [PHASES];

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_AREA_WIDTH;
        i_cfg_data      <= '0;
        cmd_if.valid    <= 1'b0;
        cmd_if.op       <= OP_WRITE;
        cmd_if.pos_x    <= '0;
        cmd_if.pos_y    <= '0;
        cmd_if.solid_in <= 1'b0;

        area_w_q = int'(AREA_WIDTH_RST);
        area_h_q = int'(AREA_HEIGHT_RST);
        radius_q = int'(BLAST_RADIUS_RST);

        // Directed part. Starts on the reset setting (full map, radius 40).
        // Typed answers where they are obvious, predictor elsewhere.
        plan = '{
            word_row(OP_WRITE,   0,    0,   1'b1, 1'b1, 1'b0),
            word_row(OP_READ,    0,    0,   1'b0, 1'b1, 1'b1),
            word_row(OP_WRITE,   1023, 511, 1'b1, 1'b1, 1'b0),
            word_row(OP_READ,    1023, 511, 1'b0, 1'b1, 1'b1),
            // unused op must leave the pixel alone
            word_row(OP_SPARE,   1023, 511, 1'b0, 1'b1, 1'b0),
            word_row(OP_READ,    1023, 511, 1'b0, 1'b1, 1'b1),
            // the innermost ring clears the centre itself
            word_row(OP_WRITE,   512,  256, 1'b1, 1'b1, 1'b0),
            word_row(OP_EXPLODE, 512,  256, 1'b0, 1'b1, 1'b0),
            word_row(OP_READ,    512,  256, 1'b0, 1'b1, 1'b0),
            // corner blast: most points fall off the map
            word_row(OP_EXPLODE, 0,    0,   1'b0, 1'b1, 1'b0),
            word_row(OP_READ,    0,    0,   1'b0, 1'b1, 1'b0),
            // small area: edges and just past them
            cfg_row(10, 12, 3),
            word_row(OP_WRITE,   9,    11,  1'b1, 1'b1, 1'b0),
            word_row(OP_READ,    9,    11,  1'b0, 1'b1, 1'b1),
            word_row(OP_WRITE,   10,   0,   1'b1, 1'b1, 1'b0),
            word_row(OP_READ,    10,   0,   1'b0, 1'b1, 1'b0),
            word_row(OP_READ,    0,    12,  1'b0, 1'b1, 1'b0),
            word_row(OP_EXPLODE, 9,    11,  1'b0, 1'b1, 1'b0),
            word_row(OP_READ,    9,    11,  1'b0, 1'b1, 1'b0),
            // registers beyond the map clip to it; largest radius at an edge
            cfg_row(2047, 1023, 63),
            word_row(OP_EXPLODE, 1023, 0,   1'b0, 1'b1, 1'b0),
            word_row(OP_READ,    1023, 511, 1'b0, 1'b0, 1'b0),
            // zero width: nothing is on the map
            cfg_row(0, 512, 0),
            word_row(OP_READ,    3,    3,   1'b0, 1'b1, 1'b0),
            word_row(OP_EXPLODE, 3,    3,   1'b0, 1'b1, 1'b0),
            // zero height: writes fall away
            cfg_row(1024, 0, 5),
            word_row(OP_WRITE,   5,    5,   1'b1, 1'b1, 1'b0),
            // radius zero clears a single pixel
            cfg_row(1024, 512, 0),
            word_row(OP_EXPLODE, 1,    1,   1'b0, 1'b1, 1'b0),
            word_row(OP_READ,    1,    1,   1'b0, 1'b1, 1'b0)
        };

        // random phases: width, height, radius, words, blast share in percent
        phases = '{
            '{1024, 512,  5,  200, 8},
            '{16,   16,   3,  150, 6},
            '{37,   300,  7,  150, 6},
            '{1,    1,    1,  60,  8},
            '{2047, 1023, 2,  120, 6},
            '{1024, 512,  63, 30,  10},
            '{700,  1,    0,  80,  8},
            '{0,    512,  4,  40,  8},
            '{200,  0,    4,  40,  8},
            '{1024, 512,  40, 40,  10}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                set_config(int'(plan[i].w), int'(plan[i].h), int'(plan[i].r));
            else
                send_word(plan[i].op, int'(plan[i].x), int'(plan[i].y), plan[i].solid,
                          plan[i].has_lit, plan[i].lit);
        end

        foreach (phases[i])
            run_phase(phases[i].w, phases[i].h, phases[i].r, phases[i].words,
                      phases[i].boom_pct);

        // a few settings picked at random, small radii to keep the run short
        repeat (3)
            run_phase($urandom_range(1, 1100), $urandom_range(1, 520), $urandom_range(0, 9),
                      80, 6);

        // let the last result in, then give stray words time to show up
        drain_results(3 * SETTLE_CYCLES);
        if (due_results.size() != 0) begin
            $error("%0d results still outstanding at the end", due_results.size());
            fail_count++;
        end

        $display("Covered %0d words (%0d reads, %0d explosions) over %0d register settings.",
                 words_sent, reads_sent, blasts, settings_seen);
        $display("Results checked: %0d, failures: %0d.", results_seen, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
